// ===== rtl/core/ltc_pkg.sv =====
// Package of shared constants and types for the level transition curve block.
`timescale 1ns / 1ps

package ltc_pkg;

   // Field widths of one input word and one result word.
   localparam int CMD_W   = 4;
   localparam int PHASE_W = 17;
   localparam int LEVEL_W = 16;

   // Weights are Q1.16 in 0..65536, so they need one bit more than a level.
   localparam int WEIGHT_W = 17;
   localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

   // Default depth of the quarter-wave sine table.
   localparam int SINE_DEPTH_DEFAULT = 256;

   // Curve commands.
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE       = 4'd0,
      CMD_FULL       = 4'd1,
      CMD_LIN_RISE   = 4'd2,
      CMD_LIN_FALL   = 4'd3,
      CMD_LIN_TRANS  = 4'd4,
      CMD_SINE_RISE  = 4'd5,
      CMD_SINE_FALL  = 4'd6,
      CMD_SINE_TRANS = 4'd7,
      CMD_EXP_RISE   = 4'd8,
      CMD_EXP_FALL   = 4'd9,
      CMD_EXP_TRANS  = 4'd10
   } cmd_type;

   // Weight shape chosen by the command.
   typedef enum logic [1:0] {
      SHAPE_LIN,
      SHAPE_SINE,
      SHAPE_EXP
   } shape_type;

   // Control that travels down the pipeline beside the weight units.
   typedef struct packed {
      shape_type            shape;
      logic [LEVEL_W-1:0]   start_level;
      logic [LEVEL_W-1:0]   end_level;
      logic [WEIGHT_W-1:0]  lin_weight;
   } ctl_type;

endpackage

// ===== rtl/core/ltc_channels.sv =====
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps

interface ltc_req_if
   import ltc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [PHASE_W-1:0] phase;
   logic [LEVEL_W-1:0] current_level;
   logic [LEVEL_W-1:0] target_level;

   modport source (output valid, output cmd, output phase, output current_level,
                   output target_level, input ready);
   modport sink   (input valid, input cmd, input phase, input current_level,
                   input target_level, output ready);
endinterface

interface ltc_rsp_if
   import ltc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level_out;

   modport source (output valid, output level_out, input ready);
   modport sink   (input valid, input level_out, output ready);
endinterface

// ===== rtl/core/ltc_sine.sv =====
// Three-stage sine weight unit: table address, table read, interpolation.
`timescale 1ns / 1ps

module ltc_sine
   import ltc_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [PHASE_W-1:0]  phase,
   output logic [WEIGHT_W-1:0] weight
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int POS_W = 16 + IDX_W;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam int TAYLOR_TERMS = 8;
   localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [WEIGHT_W-1:0] tab_type [SINE_TABLE_DEPTH+1];

   // Builds the quarter-wave table at elaboration from a Taylor series in Q2.30.
   function automatic tab_type build_table();
      tab_type         tab;
      longint unsigned x;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned r;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x = (HALF_PI_Q30 * longint'(i) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
         term = x;
         sum = x;
         for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if (k % 2 == 1) begin
               if (term > sum) begin
                  sum = 0;
               end else begin
                  sum = sum - term;
               end
            end else begin
               sum = sum + term;
            end
         end
         r = (sum + 64'd8192) >> 14;
         if (r > 64'd65536) begin
            r = 64'd65536;
         end
         tab[i] = WEIGHT_W'(r);
      end
      return tab;
   endfunction

   localparam tab_type SINE_TAB = build_table();

   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;
   logic [WEIGHT_W-1:0] lo_ff, lo_in;
   logic [WEIGHT_W-1:0] hi_ff, hi_in;
   logic [15:0]         frac_ff, frac_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [IDX_W-1:0]    idx;
   logic [IDX_W-1:0]    lo_addr;
   logic [IDX_W-1:0]    hi_addr;
   logic [WEIGHT_W-1:0] step;
   logic [32:0]         interp;

   // Stage one scales the phase into a table position.
   always_comb begin
      pos_in = POS_W'(phase) * POS_W'(SINE_TABLE_DEPTH);
   end

   // Stage two reads the two neighboring entries; past the end both are the last one.
   always_comb begin
      idx = pos_ff[POS_W-1:16];
      if (idx >= IDX_W'(SINE_TABLE_DEPTH)) begin
         lo_addr = IDX_W'(SINE_TABLE_DEPTH);
         hi_addr = IDX_W'(SINE_TABLE_DEPTH);
      end else begin
         lo_addr = idx;
         hi_addr = idx + IDX_W'(1);
      end
      lo_in   = SINE_TAB[lo_addr];
      hi_in   = SINE_TAB[hi_addr];
      frac_in = pos_ff[15:0];
   end

   // Stage three interpolates between the entries with rounding.
   always_comb begin
      step      = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : '0;
      interp    = (33'(step) * 33'(frac_ff) + 33'd32768) >> 16;
      weight_in = lo_ff + interp[WEIGHT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pos_ff    <= pos_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         frac_ff   <= frac_in;
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule

// ===== rtl/core/ltc_exp.sv =====
// Three-stage exponential weight unit: phase to the eighth power by squarings.
`timescale 1ns / 1ps

module ltc_exp
   import ltc_pkg::*;
(
   input  logic                clock,
   input  logic                enable,
   input  logic [PHASE_W-1:0]  phase,
   output logic [WEIGHT_W-1:0] weight
);

   localparam int STAGES = 3;

   logic [WEIGHT_W-1:0] q_ff [STAGES];
   logic [WEIGHT_W-1:0] q_in [STAGES];

   // A rounded Q1.16 square; inputs never exceed 1.0, so the result fits.
   function automatic logic [WEIGHT_W-1:0] square_round(input logic [WEIGHT_W-1:0] q);
      logic [2*WEIGHT_W-1:0] prod;
      prod = (2*WEIGHT_W)'(q) * (2*WEIGHT_W)'(q) + (2*WEIGHT_W)'(32768);
      return prod[WEIGHT_W+15:16];
   endfunction

   // Each stage squares the value that the stage before it holds.
   always_comb begin
      q_in[0] = square_round(WEIGHT_W'(phase));
      for (int s = 1; s < STAGES; s++) begin
         q_in[s] = square_round(q_ff[s-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < STAGES; s++) begin
            q_ff[s] <= q_in[s];
         end
      end
   end

   assign weight = q_ff[STAGES-1];

endmodule

// ===== rtl/core/ltc_blend.sv =====
// Two-stage blend: weighted products, then rounded sum into the output register.
`timescale 1ns / 1ps

module ltc_blend
   import ltc_pkg::*;
(
   input  logic                clock,
   input  logic                enable,
   input  logic [LEVEL_W-1:0]  start_level,
   input  logic [LEVEL_W-1:0]  end_level,
   input  logic [WEIGHT_W-1:0] weight,
   output logic [LEVEL_W-1:0]  level_out
);

   localparam int PROD_W = LEVEL_W + WEIGHT_W;

   logic [WEIGHT_W-1:0] w_sat;
   logic [PROD_W-1:0]   start_prod_ff, start_prod_in;
   logic [PROD_W-1:0]   end_prod_ff, end_prod_in;
   logic [PROD_W:0]     sum;
   logic [LEVEL_W-1:0]  level_ff, level_in;

   // The two products run side by side.
   always_comb begin
      w_sat         = (weight > ONE_Q16) ? ONE_Q16 : weight;
      start_prod_in = PROD_W'(start_level) * PROD_W'(ONE_Q16 - w_sat);
      end_prod_in   = PROD_W'(end_level) * PROD_W'(w_sat);
   end

   // Rounded sum, held at full scale.
   always_comb begin
      sum = (PROD_W+1)'(start_prod_ff) + (PROD_W+1)'(end_prod_ff) + (PROD_W+1)'(32768);
      if (sum[PROD_W:16] > (PROD_W-15)'(16'hFFFF)) begin
         level_in = 16'hFFFF;
      end else begin
         level_in = sum[LEVEL_W+15:16];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         start_prod_ff <= start_prod_in;
         end_prod_ff   <= end_prod_in;
         level_ff      <= level_in;
      end
   end

   assign level_out = level_ff;

endmodule

// ===== rtl/core/level_transition_curve.sv =====
// Top level of the crossfade level shaping pipeline.
//
//   channel    direction   payload
//   req_chan   in          cmd, phase, current_level, target_level
//   rsp_chan   out         level_out
//
// One word enters per cycle unless a result waits and rsp_chan is not ready.
// The pipeline holds the three weight stages (sine table and interpolation,
// three squarings) and the two blend stages; the 17x17 and 16x17 multipliers
// set the stage depth. The sine table is a constant built at elaboration,
// so reset only clears the valid bits, and req_chan.ready is low while reset
// is high. When a result waits and rsp_chan is not ready, every stage holds
// and req_chan.ready is low.
`timescale 1ns / 1ps

module level_transition_curve
   import ltc_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ltc_req_if.sink     req_chan,
   ltc_rsp_if.source   rsp_chan
);

   localparam int DEPTH = 5;
   localparam int WSTAGES = 3;

   logic [DEPTH-1:0]    valid_ff, valid_in;
   ctl_type             ctl_ff [WSTAGES];
   ctl_type             ctl_in;
   logic                advance;
   logic [PHASE_W-1:0]  phase_sat;
   logic [WEIGHT_W-1:0] sine_w;
   logic [WEIGHT_W-1:0] exp_w;
   logic [WEIGHT_W-1:0] weight;

   // The whole pipeline moves unless the output word is stuck.
   assign advance        = !valid_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = advance && !reset;

   // Phase above one counts as one.
   assign phase_sat = (req_chan.phase > PHASE_W'(ONE_Q16)) ? PHASE_W'(ONE_Q16)
                                                            : req_chan.phase;

   // Command decode: shape and the two end levels. None and unknown blend zeros,
   // full blends the current level with itself.
   always_comb begin
      ctl_in.lin_weight  = WEIGHT_W'(phase_sat);
      ctl_in.shape       = SHAPE_LIN;
      ctl_in.start_level = '0;
      ctl_in.end_level   = '0;
      unique case (cmd_type'(req_chan.cmd))
         CMD_FULL: begin
            ctl_in.start_level = req_chan.current_level;
            ctl_in.end_level   = req_chan.current_level;
         end
         CMD_LIN_RISE, CMD_SINE_RISE, CMD_EXP_RISE: begin
            ctl_in.end_level   = req_chan.current_level;
         end
         CMD_LIN_FALL, CMD_SINE_FALL, CMD_EXP_FALL: begin
            ctl_in.start_level = req_chan.current_level;
         end
         CMD_LIN_TRANS, CMD_SINE_TRANS, CMD_EXP_TRANS: begin
            ctl_in.start_level = req_chan.current_level;
            ctl_in.end_level   = req_chan.target_level;
         end
         default: begin
         end
      endcase
      unique case (cmd_type'(req_chan.cmd))
         CMD_SINE_RISE, CMD_SINE_FALL, CMD_SINE_TRANS: ctl_in.shape = SHAPE_SINE;
         CMD_EXP_RISE, CMD_EXP_FALL, CMD_EXP_TRANS:    ctl_in.shape = SHAPE_EXP;
         default:                                      ctl_in.shape = SHAPE_LIN;
      endcase
   end

   // Valid bits shift with the data.
   assign valid_in = {valid_ff[DEPTH-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Control delay line beside the weight units.
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int s = 1; s < WSTAGES; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   ltc_sine #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock  (clock),
      .enable (advance),
      .phase  (phase_sat),
      .weight (sine_w)
   );

   ltc_exp u_exp (
      .clock  (clock),
      .enable (advance),
      .phase  (phase_sat),
      .weight (exp_w)
   );

   // Pick the weight of the word leaving the third stage.
   always_comb begin
      unique case (ctl_ff[WSTAGES-1].shape)
         SHAPE_SINE: weight = sine_w;
         SHAPE_EXP:  weight = exp_w;
         default:    weight = ctl_ff[WSTAGES-1].lin_weight;
      endcase
   end

   ltc_blend u_blend (
      .clock       (clock),
      .enable      (advance),
      .start_level (ctl_ff[WSTAGES-1].start_level),
      .end_level   (ctl_ff[WSTAGES-1].end_level),
      .weight      (weight),
      .level_out   (rsp_chan.level_out)
   );

   assign rsp_chan.valid = valid_ff[DEPTH-1];

endmodule
